>>> rtl/core/sci_pkg.sv
package sci_pkg;

   localparam int PARTS_DEFAULT      = 8;
   localparam int CAL_ROUNDS_DEFAULT = 3;
   localparam int OFFSET_W           = 12;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd155;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_CAL  = 2'd1,
      OP_RUN  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SEEK   = 3'd1,
      PH_BACK   = 3'd2,
      PH_RESEEK = 3'd3,
      PH_RIN    = 3'd4,
      PH_ROUT   = 3'd5,
      PH_ADV    = 3'd6,
      PH_RUN    = 3'd7
   } phase_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic signed [7:0] turns;
      logic              sensor_clear;
   } req_type;

   typedef struct packed {
      logic [3:0]  coils;
      logic        busy_res;
      logic        calibrated;
      logic [15:0] steps_per_turn;
      logic        rejected;
   } rsp_type;

   // Half-step drive pattern, bit 0 is the first coil.
   function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h1;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/core/sci_const_div.sv
module sci_const_div
   import sci_pkg::*;
#(
   parameter int IN_W    = 16,
   parameter int DIVISOR = 3,
   localparam int REM_W  = $clog2(DIVISOR) + 1
) (
   input  logic [IN_W-1:0]  x,
   output logic [IN_W-1:0]  quot,
   output logic [REM_W-1:0] rem
);

   // The truncated reciprocal undershoots the quotient by at most one.
   localparam logic [IN_W:0] RECIP = (IN_W+1)'((2**IN_W) / DIVISOR);

   logic [2*IN_W:0] prod;
   logic [IN_W-1:0] q0;
   logic [IN_W-1:0] back;
   logic [IN_W-1:0] r0;
   logic            fix;

   assign prod = (2*IN_W+1)'(x) * (2*IN_W+1)'(RECIP);
   assign q0   = prod[2*IN_W-1:IN_W];
   assign back = q0 * IN_W'(DIVISOR);
   assign r0   = x - back;
   assign fix  = (r0 >= IN_W'(DIVISOR));
   assign quot = q0 + IN_W'(fix);
   assign rem  = fix ? REM_W'(r0 - IN_W'(DIVISOR)) : REM_W'(r0);

endmodule

>>> rtl/core/sci_engine.sv
module sci_engine
   import sci_pkg::*;
#(
   parameter int PARTS      = PARTS_DEFAULT,
   parameter int CAL_ROUNDS = CAL_ROUNDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  req_type             item,
   input  logic [OFFSET_W-1:0] offset,
   output rsp_type             result
);

   localparam int PIW = $clog2(PARTS);
   localparam logic [PIW:0]   PARTS_W   = (PIW+1)'(PARTS);
   localparam logic [PIW-1:0] LAST_PART = PIW'(PARTS - 1);
   localparam logic [PIW-1:0] PREV_LAST = PIW'(PARTS - 2);
   localparam logic [7:0]     PARTS_8   = 8'(PARTS);

   // Entry n holds n modulo the ring size.
   function automatic logic [256*PIW-1:0] build_mod_table();
      logic [256*PIW-1:0] t;
      int                 c;
      t = '0;
      c = 0;
      for (int i = 0; i < 256; i++) begin
         t[i*PIW +: PIW] = PIW'(c);
         c = (c == PARTS - 1) ? 0 : c + 1;
      end
      return t;
   endfunction

   localparam logic [256*PIW-1:0] MOD_TABLE = build_mod_table();

   phase_type      phase_ff, phase_in;
   logic [2:0]     seq_ff, seq_in;
   logic [1:0]     round_idx_ff, round_idx_in;
   logic [15:0]    round_steps_ff, round_steps_in;
   logic [17:0]    round_sum_ff, round_sum_in;
   logic [15:0]    avg_ff, avg_in;
   logic           cal_ff, cal_in;
   logic [PIW-1:0] part_idx_ff, part_idx_in;
   logic [7:0]     parts_left_ff, parts_left_in;
   logic [16:0]    steps_left_ff, steps_left_in;
   logic           backward_ff, backward_in;
   logic [15:0]    part_base_ff;
   logic [PIW-1:0] part_rem_ff;

   logic           move_fwd, move_back, count_step, rej;
   logic [17:0]    sum_new;
   logic [17:0]    sum_quot;
   logic [15:0]    avg_new;
   logic [16:0]    adv_total;
   logic [15:0]    steps_inc;
   logic [15:0]    base_quot;
   logic [$clog2(PARTS):0] base_rem;
   logic [16:0]    part_len;
   logic [7:0]     skip_cnt;
   logic [PIW-1:0] mod_r;
   logic [PIW:0]   wrap_sum;
   logic [PIW-1:0] wrap_fwd, wrap_bwd, idx_next, idx_prev;
   logic           busy;

   sci_const_div #(.IN_W(18), .DIVISOR(CAL_ROUNDS)) u_avg_div (
      .x    (sum_new),
      .quot (sum_quot),
      .rem  ()
   );

   sci_const_div #(.IN_W(16), .DIVISOR(PARTS)) u_part_div (
      .x    (avg_ff),
      .quot (base_quot),
      .rem  (base_rem)
   );

   assign busy      = (phase_ff != PH_IDLE);
   assign sum_new   = round_sum_ff + {2'b00, round_steps_ff};
   assign avg_new   = sum_quot[15:0];
   assign adv_total = {1'b0, avg_new} + 17'(offset);
   assign steps_inc = (round_steps_ff == 16'hFFFF) ? round_steps_ff : round_steps_ff + 16'd1;

   assign part_len = {1'b0, part_base_ff} +
                     ((part_idx_ff == LAST_PART) ? 17'(part_rem_ff) : 17'd0);
   assign idx_next = (part_idx_ff == LAST_PART) ? '0 : part_idx_ff + PIW'(1);
   assign idx_prev = (part_idx_ff == '0) ? LAST_PART : part_idx_ff - PIW'(1);

   // Zero-length parts ahead of the last one, when only the last part has steps.
   assign skip_cnt = backward_ff ?
                     ((part_idx_ff == LAST_PART) ? 8'd0 : 8'(part_idx_ff) + 8'd1) :
                     8'(LAST_PART - part_idx_ff);

   assign mod_r    = MOD_TABLE[parts_left_ff * PIW +: PIW];
   assign wrap_sum = {1'b0, part_idx_ff} + {1'b0, mod_r};
   assign wrap_fwd = (wrap_sum >= PARTS_W) ? PIW'(wrap_sum - PARTS_W) : PIW'(wrap_sum);
   assign wrap_bwd = (part_idx_ff >= mod_r) ? part_idx_ff - mod_r :
                     PIW'({1'b0, part_idx_ff} + PARTS_W - {1'b0, mod_r});

   always_comb begin
      phase_in       = phase_ff;
      round_idx_in   = round_idx_ff;
      round_steps_in = round_steps_ff;
      round_sum_in   = round_sum_ff;
      avg_in         = avg_ff;
      cal_in         = cal_ff;
      part_idx_in    = part_idx_ff;
      parts_left_in  = parts_left_ff;
      steps_left_in  = steps_left_ff;
      backward_in    = backward_ff;
      move_fwd       = 1'b0;
      move_back      = 1'b0;
      count_step     = 1'b0;
      rej            = 1'b0;

      case (item.opcode)
         OP_CAL: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               phase_in       = PH_SEEK;
               round_idx_in   = 2'd0;
               round_steps_in = 16'd0;
               round_sum_in   = 18'd0;
            end
         end
         OP_RUN: begin
            if (busy || !cal_ff) begin
               rej = 1'b1;
            end else begin
               steps_left_in = 17'd0;
               phase_in      = PH_RUN;
               if (item.turns == 8'sd0) begin
                  parts_left_in = PARTS_8;
                  backward_in   = 1'b0;
               end else if (item.turns[7]) begin
                  parts_left_in = $unsigned(-item.turns);
                  backward_in   = 1'b1;
               end else begin
                  parts_left_in = $unsigned(item.turns);
                  backward_in   = 1'b0;
               end
            end
         end
         default: begin
            // A tick that ends a phase takes the next phase's step at once.
            case (phase_ff)
               PH_SEEK: begin
                  if (item.sensor_clear) begin
                     move_fwd = 1'b1;
                  end else begin
                     phase_in  = PH_BACK;
                     move_back = 1'b1;
                  end
               end
               PH_BACK: begin
                  if (!item.sensor_clear) begin
                     move_back = 1'b1;
                  end else begin
                     phase_in = PH_RESEEK;
                     move_fwd = 1'b1;
                  end
               end
               PH_RESEEK: begin
                  move_fwd   = 1'b1;
                  count_step = !item.sensor_clear;
                  if (!item.sensor_clear) begin
                     phase_in = PH_RIN;
                  end
               end
               PH_RIN: begin
                  move_fwd   = 1'b1;
                  count_step = 1'b1;
                  if (item.sensor_clear) begin
                     phase_in = PH_ROUT;
                  end
               end
               PH_ROUT: begin
                  if (item.sensor_clear) begin
                     move_fwd   = 1'b1;
                     count_step = 1'b1;
                  end else begin
                     round_sum_in   = sum_new;
                     round_steps_in = 16'd0;
                     round_idx_in   = round_idx_ff + 2'd1;
                     if (32'(round_idx_in) >= CAL_ROUNDS) begin
                        avg_in = avg_new;
                        if (adv_total != 17'd0) begin
                           phase_in      = PH_ADV;
                           steps_left_in = adv_total - 17'd1;
                           move_fwd      = 1'b1;
                        end else begin
                           steps_left_in = 17'd0;
                           cal_in        = 1'b1;
                           phase_in      = PH_IDLE;
                        end
                     end else begin
                        phase_in       = PH_RIN;
                        move_fwd       = 1'b1;
                        round_steps_in = 16'd1;
                     end
                  end
               end
               PH_ADV: begin
                  if (steps_left_ff != 17'd0) begin
                     move_fwd      = 1'b1;
                     steps_left_in = steps_left_ff - 17'd1;
                  end else begin
                     cal_in   = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               PH_RUN: begin
                  if (steps_left_ff != 17'd0) begin
                     move_fwd      = !backward_ff;
                     move_back     = backward_ff;
                     steps_left_in = steps_left_ff - 17'd1;
                  end else if (parts_left_ff == 8'd0) begin
                     phase_in = PH_IDLE;
                  end else if (part_base_ff != 16'd0) begin
                     steps_left_in = part_len - 17'd1;
                     part_idx_in   = backward_ff ? idx_prev : idx_next;
                     parts_left_in = parts_left_ff - 8'd1;
                     move_fwd      = !backward_ff;
                     move_back     = backward_ff;
                  end else if (part_rem_ff == '0 || parts_left_ff <= skip_cnt) begin
                     // Every remaining part is empty: the run ends in this tick.
                     part_idx_in   = backward_ff ? wrap_bwd : wrap_fwd;
                     parts_left_in = 8'd0;
                     phase_in      = PH_IDLE;
                  end else begin
                     part_idx_in   = backward_ff ? PREV_LAST : '0;
                     parts_left_in = parts_left_ff - skip_cnt - 8'd1;
                     steps_left_in = 17'(part_rem_ff) - 17'd1;
                     move_fwd      = !backward_ff;
                     move_back     = backward_ff;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      endcase

      if (count_step) begin
         round_steps_in = steps_inc;
      end

      if (move_fwd) begin
         seq_in = seq_ff + 3'd1;
      end else if (move_back) begin
         seq_in = seq_ff - 3'd1;
      end else begin
         seq_in = seq_ff;
      end

      result.coils          = coil_pattern(seq_in);
      result.busy_res       = (phase_in != PH_IDLE);
      result.calibrated     = cal_in;
      result.steps_per_turn = avg_in;
      result.rejected       = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         seq_ff         <= 3'd0;
         round_idx_ff   <= 2'd0;
         round_steps_ff <= 16'd0;
         round_sum_ff   <= 18'd0;
         avg_ff         <= 16'd0;
         cal_ff         <= 1'b0;
         part_idx_ff    <= '0;
         parts_left_ff  <= 8'd0;
         steps_left_ff  <= 17'd0;
         backward_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         seq_ff         <= seq_in;
         round_idx_ff   <= round_idx_in;
         round_steps_ff <= round_steps_in;
         round_sum_ff   <= round_sum_in;
         avg_ff         <= avg_in;
         cal_ff         <= cal_in;
         part_idx_ff    <= part_idx_in;
         parts_left_ff  <= parts_left_in;
         steps_left_ff  <= steps_left_in;
         backward_ff    <= backward_in;
      end
   end

   // Part length is registered from the average in the next cycle; a run can never use
   // it sooner, since a start command always sits between.
   always_ff @(posedge clock) begin
      part_base_ff <= base_quot;
      part_rem_ff  <= PIW'(base_rem);
   end

endmodule

>>> rtl/core/stepper_calibrate_and_index.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_data (req_type)
// rsp_      out        rsp_valid / rsp_stall  rsp_data (rsp_type)
// csr_      in         csr_valid / csr_ready  csr_data (opening offset)
//
// Every item gives one result item; one item is taken per cycle while the result side does not stall.
// An item is held in the input register until it can advance, and its
// result is then registered in the result register.
// Reset is synchronous and leaves the drive idle and uncalibrated.
// A stall on the result side holds the result register and then the input.
module stepper_calibrate_and_index
   import sci_pkg::*;
#(
   parameter int PARTS      = PARTS_DEFAULT,
   parameter int CAL_ROUNDS = CAL_ROUNDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [OFFSET_W-1:0] csr_data
);

   logic                in_valid_ff, in_valid_in;
   req_type             in_item_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_item_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic                advance;
   logic                req_take;
   rsp_type             result;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   sci_engine #(.PARTS(PARTS), .CAL_ROUNDS(CAL_ROUNDS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .offset  (offset_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         offset_ff    <= OFFSET_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            offset_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import sci_pkg::*;

   localparam int ITEM_GOAL   = 1000;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int PART_COUNT  = PARTS_DEFAULT;
   localparam int ROUND_COUNT = CAL_ROUNDS_DEFAULT;

   // The spare opcode value behaves as a tick.
   localparam logic [1:0] OP_SPARE = 2'd3;

   // Half-step coil patterns, entry 0 in the low nibble.
   localparam logic [31:0] HALF_STEP = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [OFFSET_W-1:0] csr_data;

   int cycles = 0;
   int items_sent = 0;
   int hold_requests = 0;
   int holds_done = 0;

   class stepper_scoreboard;
      logic [11:0] offset;
      phase_type   phase;
      logic [2:0]  seq;
      logic [1:0]  round_idx;
      logic [15:0] round_steps;
      logic [17:0] round_sum;
      logic [15:0] avg_steps;
      logic        calibrated;
      logic [2:0]  part_idx;
      logic [7:0]  parts_left;
      logic [16:0] steps_left;
      logic        backward;
      rsp_type     drive_status_q[$];
      int          failures;

      function new();
         offset      = OFFSET_RESET;
         phase       = PH_IDLE;
         seq         = '0;
         round_idx   = '0;
         round_steps = '0;
         round_sum   = '0;
         avg_steps   = '0;
         calibrated  = 1'b0;
         part_idx    = '0;
         parts_left  = '0;
         steps_left  = '0;
         backward    = 1'b0;
         failures    = 0;
      endfunction

      function logic [16:0] part_length(logic [2:0] idx);
         logic [16:0] len;
         len = 17'(int'(avg_steps) / PART_COUNT);
         // The last part of the ring takes the remainder.
         if (int'(idx) == PART_COUNT - 1)
            len = len + 17'(int'(avg_steps) % PART_COUNT);
         return len;
      endfunction

      // One tick moves at most one half-step; phases that end on this
      // sensor level fall through to the next phase within the tick.
      function void advance_drive(logic clear);
         bit done;
         done = 1'b0;
         for (int guard = 0; guard < 1000 && !done; guard++) begin
            case (phase)
               PH_SEEK: begin
                  if (clear) begin
                     seq = seq + 3'd1;
                     done = 1'b1;
                  end else
                     phase = PH_BACK;
               end
               PH_BACK: begin
                  if (!clear) begin
                     seq = seq - 3'd1;
                     done = 1'b1;
                  end else
                     phase = PH_RESEEK;
               end
               PH_RESEEK: begin
                  if (clear) begin
                     seq = seq + 3'd1;
                     done = 1'b1;
                  end else
                     phase = PH_RIN;
               end
               PH_RIN: begin
                  if (!clear) begin
                     seq = seq + 3'd1;
                     if (round_steps != 16'hFFFF) round_steps = round_steps + 16'd1;
                     done = 1'b1;
                  end else
                     phase = PH_ROUT;
               end
               PH_ROUT: begin
                  if (clear) begin
                     seq = seq + 3'd1;
                     if (round_steps != 16'hFFFF) round_steps = round_steps + 16'd1;
                     done = 1'b1;
                  end else begin
                     round_sum   = round_sum + 18'(round_steps);
                     round_steps = '0;
                     round_idx   = round_idx + 2'd1;
                     if (int'(round_idx) >= ROUND_COUNT) begin
                        avg_steps  = 16'(int'(round_sum) / ROUND_COUNT);
                        steps_left = 17'(avg_steps) + 17'(offset);
                        phase      = PH_ADV;
                     end else
                        phase = PH_RIN;
                  end
               end
               PH_ADV: begin
                  if (steps_left != 0) begin
                     seq = seq + 3'd1;
                     steps_left = steps_left - 17'd1;
                  end else begin
                     calibrated = 1'b1;
                     phase = PH_IDLE;
                  end
                  done = 1'b1;
               end
               PH_RUN: begin
                  if (steps_left != 0) begin
                     seq = backward ? seq - 3'd1 : seq + 3'd1;
                     steps_left = steps_left - 17'd1;
                     done = 1'b1;
                  end else if (parts_left == 0) begin
                     phase = PH_IDLE;
                     done = 1'b1;
                  end else begin
                     steps_left = part_length(part_idx);
                     part_idx   = backward ? part_idx - 3'd1 : part_idx + 3'd1;
                     parts_left = parts_left - 8'd1;
                  end
               end
               default: begin
                  phase = PH_IDLE;
                  done = 1'b1;
               end
            endcase
         end
      endfunction

      function void note_command(req_type item);
         rsp_type st;
         logic    rej;
         rej = 1'b0;
         case (item.opcode)
            OP_CAL: begin
               if (phase != PH_IDLE)
                  rej = 1'b1;
               else begin
                  phase       = PH_SEEK;
                  round_idx   = '0;
                  round_steps = '0;
                  round_sum   = '0;
               end
            end
            OP_RUN: begin
               if (phase != PH_IDLE || !calibrated)
                  rej = 1'b1;
               else begin
                  steps_left = '0;
                  if (item.turns == '0) begin
                     parts_left = 8'(PART_COUNT);
                     backward   = 1'b0;
                  end else if (item.turns[7]) begin
                     parts_left = 8'd0 - item.turns;
                     backward   = 1'b1;
                  end else begin
                     parts_left = item.turns;
                     backward   = 1'b0;
                  end
                  phase = PH_RUN;
               end
            end
            default: advance_drive(item.sensor_clear);
         endcase
         st.coils          = HALF_STEP[4*seq +: 4];
         st.busy_res       = (phase != PH_IDLE);
         st.calibrated     = calibrated;
         st.steps_per_turn = avg_steps;
         st.rejected       = rej;
         drive_status_q.push_back(st);
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (drive_status_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result item: coils %h busy %b cal %b steps %0d rej %b",
                        got.coils, got.busy_res, got.calibrated, got.steps_per_turn,
                        got.rejected);
            return;
         end
         want = drive_status_q.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $write("mismatch (expected/actual): coils %h/%h busy %b/%b cal %b/%b ",
                      want.coils, got.coils, want.busy_res, got.busy_res,
                      want.calibrated, got.calibrated);
               $display("steps %0d/%0d rej %b/%b", want.steps_per_turn,
                        got.steps_per_turn, want.rejected, got.rejected);
            end
         end
      endfunction
   endclass

   stepper_scoreboard board;

   stepper_calibrate_and_index dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** stepper_calibrate_and_index: FAILED **");
         $finish;
      end
   end

   // Both sides skip their random idling for a quarter of the time, in a recurring window.
   function automatic bit quiet();
      return (cycles % 4000) >= 3000;
   endfunction

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_status(rsp_data);
         if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= !quiet() && ($urandom_range(0, 99) < 11);
      end
   end

   task automatic send_item(logic [1:0] op, logic [7:0] turns, logic clear);
      req_type item;
      item.opcode       = op;
      item.turns        = turns;
      item.sensor_clear = clear;
      while (!quiet() && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_command(item);
      items_sent++;
   endtask

   task automatic sensor_run(int n, logic level, bit noisy);
      repeat (n) begin
         if (noisy && $urandom_range(0, 99) < 8)
            send_item(2'($urandom), 8'($urandom), 1'($urandom));
         else
            send_item(OP_TICK, 8'($urandom), level);
      end
   endtask

   task automatic tick_until_idle(bit noisy);
      int guard;
      guard = 0;
      while (board.phase != PH_IDLE && guard < 200000) begin
         if (noisy && $urandom_range(0, 99) < 4)
            send_item(2'($urandom), 8'($urandom), 1'($urandom));
         else
            send_item(OP_TICK, 8'($urandom), 1'($urandom));
         guard++;
      end
   endtask

   // Sensor levels of a calibration: clear until the slot, back out of it,
   // forward to it again, then one slot and one gap per revolution.
   task automatic slot_sequence(int first_slot, int slot, int gap, bit noisy);
      sensor_run($urandom_range(1, 10), 1'b1, noisy);
      sensor_run($urandom_range(1, 4), 1'b0, noisy);
      sensor_run($urandom_range(1, 4), 1'b1, noisy);
      for (int r = 0; r < ROUND_COUNT; r++) begin
         sensor_run((r == 0) ? first_slot : slot + $urandom_range(0, 2), 1'b0, noisy);
         sensor_run(gap + $urandom_range(0, 2), 1'b1, noisy);
      end
      sensor_run(1, 1'b0, noisy);
      tick_until_idle(noisy);
   endtask

   task automatic run_parts(logic [7:0] turns, bit noisy);
      send_item(OP_RUN, turns, 1'($urandom));
      tick_until_idle(noisy);
   endtask

   task automatic write_offset(logic [11:0] value);
      req_valid <= 1'b0;
      while (board.drive_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.offset = value;
   endtask

   initial begin
      int         last_cfg;
      int         pick;
      logic [7:0] turns;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      board     = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Idle ticks hold the pattern; runs before calibration are refused.
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_TICK, 8'hFF, 1'b1);
      send_item(OP_SPARE, 8'h80, 1'b1);
      send_item(OP_RUN, 8'h00, 1'b1);
      send_item(OP_RUN, 8'h7F, 1'b0);

      // Commands that arrive during a calibration are refused.
      send_item(OP_CAL, 8'h00, 1'b0);
      send_item(OP_CAL, 8'h01, 1'b1);
      send_item(OP_RUN, 8'h05, 1'b0);
      slot_sequence(4, 4, 20, 1'b0);

      send_item(OP_RUN, 8'h00, 1'b0);
      send_item(OP_RUN, 8'h01, 1'b1);
      send_item(OP_CAL, 8'h00, 1'b1);
      tick_until_idle(1'b0);
      run_parts(8'h01, 1'b0);
      run_parts(8'hFF, 1'b0);

      // Tiny revolutions give parts of length zero.
      write_offset(12'd0);
      send_item(OP_CAL, 8'h00, 1'b1);
      slot_sequence(1, 1, 1, 1'b0);
      run_parts(8'h03, 1'b0);
      run_parts(8'h7F, 1'b0);
      run_parts(8'h80, 1'b0);

      write_offset(12'd100);
      send_item(OP_CAL, 8'h00, 1'b1);
      slot_sequence(3, 3, 10, 1'b0);
      run_parts(8'h02, 1'b0);

      write_offset(12'($urandom_range(0, 60)));
      hold_requests <= hold_requests + 1;
      last_cfg = items_sent;
      while (items_sent < ITEM_GOAL) begin
         if (items_sent - last_cfg >= 300) begin
            write_offset(12'($urandom_range(0, 60)));
            last_cfg = items_sent;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40 || !board.calibrated) begin
            send_item(OP_CAL, 8'($urandom), 1'($urandom));
            slot_sequence($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(3, 25),
                          $urandom_range(0, 3) == 0);
         end else if (pick < 85) begin
            if ($urandom_range(0, 3) == 0)
               turns = 8'($urandom);
            else
               turns = 8'($urandom_range(0, 16) - 8);
            run_parts(turns, $urandom_range(0, 2) == 0);
         end else begin
            repeat ($urandom_range(3, 15))
               send_item(2'($urandom), 8'($urandom), 1'($urandom));
            tick_until_idle(1'b0);
         end
      end

      req_valid <= 1'b0;
      while (board.drive_status_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failures == 0)
         $display("** stepper_calibrate_and_index: PASSED **");
      else
         $display("** stepper_calibrate_and_index: FAILED **");
      $finish;
   end

endmodule

>>> files.f
rtl/core/sci_pkg.sv
rtl/core/sci_const_div.sv
rtl/core/sci_engine.sv
rtl/core/stepper_calibrate_and_index.sv
tb/sv/testbench.sv
